[rtl/cbtc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbtc_pkg
// Shared types, constants and CRC-32 helpers for the block trailer checker.
// ----------------------------------------------------------------------------
package cbtc_pkg;

  localparam logic [31:0] CrcInit    = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcXorOut  = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly    = 32'hEDB8_8320;
  localparam int unsigned HeldCountW = 3;
  localparam logic [HeldCountW-1:0] TrailerBytes = HeldCountW'(4);
  localparam int unsigned QueueDepthDefault = 2;

  typedef enum logic {
    ITEM_MID,
    ITEM_LAST
  } item_kind_e;

  typedef struct packed {
    logic [7:0] data;
    item_kind_e kind;
  } queue_entry_t;

  typedef struct packed {
    logic         valid;
    queue_entry_t entry;
  } queue_head_t;

  // Reflected CRC-32 table entry for one index byte.
  function automatic logic [31:0] crc_table(input logic [7:0] idx);
    logic [31:0] c;
    c = {24'h00_0000, idx};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  // Advance the running CRC by one byte.
  function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
    return {8'h00, crc[31:8]} ^ crc_table(crc[7:0] ^ b);
  endfunction

endpackage

[rtl/crc32_block_trailer_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32_block_trailer_check
// Reflected CRC-32 check of a byte block against its four-byte trailer.
// ----------------------------------------------------------------------------
// Bytes arrive one per item with last_byte_i on the final one. The block
// takes one byte every cycle while its queue has room: the back end does a
// single table-driven CRC update per byte, and a short queue between the
// input and the CRC engine lets either side stall. The CRC covers all bytes
// but the last four, which are compared little-endian with the computed
// value; one result item per block is registered when its final byte
// leaves the queue, with too_short_o set for blocks under four bytes.
module crc32_block_trailer_check #(
  parameter int unsigned QueueDepth = cbtc_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        crc_match_o,
  output logic [31:0] computed_crc_o,
  output logic        too_short_o
);
  import cbtc_pkg::*;

  queue_head_t head;
  logic        pop;

  cbtc_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .data_byte_i(data_byte_i),
    .last_byte_i(last_byte_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  cbtc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .crc_match_o   (crc_match_o),
    .computed_crc_o(computed_crc_o),
    .too_short_o   (too_short_o)
  );

`ifndef SYNTHESIS
  a_full_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> head.valid)
    else $error("queue full but no head item");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(pop && head.entry.kind == ITEM_LAST))
    else $error("result without a final byte");

  a_short_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && too_short_o) |-> (!crc_match_o && computed_crc_o == 32'h0))
    else $error("short block reported a match or nonzero crc");

  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid)
    else $error("pop from empty queue");
`endif

endmodule

[rtl/cbtc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbtc_front
// Input side: accepts bytes, tags each as mid-block or last, and queues them.
// ----------------------------------------------------------------------------
module cbtc_front #(
  parameter int unsigned QueueDepth = cbtc_pkg::QueueDepthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_byte_i,
  output cbtc_pkg::queue_head_t head_o,
  input  logic                  pop_i
);
  import cbtc_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QueueDepth);

  queue_entry_t          store_q [QueueDepth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  push;
  queue_entry_t          entry_in;

  assign in_ready_o = (cnt_q != CntFull);
  assign push       = in_valid_i && in_ready_o;

  always_comb begin
    entry_in.data = data_byte_i;
    entry_in.kind = last_byte_i ? ITEM_LAST : ITEM_MID;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wr_ptr_q] <= entry_in;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.entry = store_q[rd_ptr_q];

endmodule

[rtl/cbtc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbtc_back
// CRC side: runs the CRC behind a four-byte window and registers the verdict.
// ----------------------------------------------------------------------------
module cbtc_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cbtc_pkg::queue_head_t head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  crc_match_o,
  output logic [31:0]           computed_crc_o,
  output logic                  too_short_o
);
  import cbtc_pkg::*;

  logic [31:0]           crc_q, crc_d;
  logic [7:0]            win_q [4];
  logic [7:0]            win_d [4];
  logic [HeldCountW-1:0] held_q, held_d;
  logic                  out_valid_q, out_valid_d;
  logic                  match_q, match_d;
  logic [31:0]           res_crc_q, res_crc_d;
  logic                  short_q, short_d;
  logic                  is_last;
  logic                  full;
  logic [31:0]           final_crc;
  logic [31:0]           trailer;

  assign is_last = (head_i.entry.kind == ITEM_LAST);
  assign full    = (held_q == TrailerBytes);
  // Mid-block bytes never touch the result register, so they always drain.
  assign pop_o   = head_i.valid && (!is_last || !out_valid_q || out_ready_i);

  always_comb begin
    crc_d  = crc_q;
    win_d  = win_q;
    held_d = held_q;
    if (full) begin
      crc_d    = crc_feed(crc_q, win_q[0]);
      win_d[0] = win_q[1];
      win_d[1] = win_q[2];
      win_d[2] = win_q[3];
      win_d[3] = head_i.entry.data;
    end else begin
      win_d[held_q[1:0]] = head_i.entry.data;
      held_d             = held_q + HeldCountW'(1);
    end

    final_crc = crc_d ^ CrcXorOut;
    trailer   = {win_d[3], win_d[2], win_d[1], win_d[0]};
    short_d   = (held_d != TrailerBytes);
    match_d   = !short_d && (trailer == final_crc);
    res_crc_d = final_crc;

    // Start the next block from a clean state.
    if (is_last) begin
      crc_d  = CrcInit;
      held_d = '0;
    end

    out_valid_d = out_valid_q && !out_ready_i;
    if (pop_o && is_last) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= CrcInit;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        crc_q  <= crc_d;
        held_q <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      win_q <= win_d;
    end
    if (pop_o && is_last) begin
      match_q   <= match_d;
      res_crc_q <= res_crc_d;
      short_q   <= short_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign crc_match_o    = match_q;
  assign computed_crc_o = res_crc_q;
  assign too_short_o    = short_q;

endmodule
